/* rtl/lir_pkg.sv */
// Shared widths, constants and types of the linear-interpolation resampler.
package lir_pkg;

    // Fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int PHASE_W  = 20;
    localparam int STEP_W   = 20;

    // Difference of two samples, partial-product high word, final sum
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int HI_W   = SAMPLE_W + 2;
    localparam int SUM_W  = SAMPLE_W + 4;

    // Parameter defaults
    localparam int FRAC_BITS_DEF = 15;
    localparam int MAX_RUN_DEF   = 64;

    // Reset value of the step register
    localparam logic [STEP_W-1:0] STEP_RESET = 20'd32768;

    // Saturation limits
    localparam logic signed [SUM_W-1:0] SAMPLE_MAX = 20'sd32767;
    localparam logic signed [SUM_W-1:0] SAMPLE_MIN = -20'sd32768;

    // Result of the serial multiplier: floor(diff*frac / 2^FRAC) and the rounding bit
    typedef struct packed {
        logic signed [HI_W-1:0] hi;
        logic                   rnd;
    } mul_res_t;

endpackage

/* rtl/lir_serial_mul.sv */
// Bit-serial multiplier: signed sample difference times unsigned phase fraction.
module lir_serial_mul #(
    parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [lir_pkg::DIFF_W-1:0]  diff,
    input  logic        [FRAC_BITS-1:0]        frac,
    output logic                               done,
    output lir_pkg::mul_res_t                  res
);
    import lir_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam int ACC_W = HI_W + FRAC_BITS;

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic        [FRAC_BITS-1:0] fsh_reg;
    logic signed [DIFF_W-1:0] d_reg;
    logic        [CNT_W-1:0]  cnt_reg;
    logic                     done_reg;
    logic signed [HI_W-1:0]   addend;
    logic signed [HI_W-1:0]   hi_sum;

    // One multiplier bit per cycle: add into the high word, then shift right
    always_comb
    begin
        addend   = fsh_reg[0] ? HI_W'(d_reg) : '0;
        hi_sum   = acc_reg[ACC_W-1:FRAC_BITS] + addend;
        acc_next = {hi_sum[HI_W-1], hi_sum, acc_reg[FRAC_BITS-1:1]};
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            fsh_reg <= frac;
            d_reg   <= diff;
        end
        else if (cnt_reg != '0)
        begin
            acc_reg <= acc_next;
            fsh_reg <= fsh_reg >> 1;
        end
    end

    // Bit counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && (cnt_reg == CNT_W'(1));
            if (start)
                cnt_reg <= CNT_W'(FRAC_BITS);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign done    = done_reg;
    assign res.hi  = acc_reg[ACC_W-1:FRAC_BITS];
    assign res.rnd = acc_reg[FRAC_BITS-1];

endmodule

/* rtl/lir_out.sv */
// Output stage: final add, rounding, saturation and the result register.
module lir_out (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    output logic                                load_ready,
    input  logic signed [lir_pkg::SAMPLE_W-1:0] base,
    input  lir_pkg::mul_res_t                   res,
    input  logic                                last_in,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic        [lir_pkg::SAMPLE_W-1:0] m_tdata,
    output logic                                m_tlast
);
    import lir_pkg::*;

    logic                       valid_reg;
    logic        [SAMPLE_W-1:0] data_reg;
    logic                       last_reg;
    logic signed [SUM_W-1:0]    sum;
    logic        [SAMPLE_W-1:0] sat;

    // base + rounded interpolation term, clamped to the sample range
    always_comb
    begin
        sum = SUM_W'(base) + SUM_W'(res.hi) + SUM_W'({1'b0, res.rnd});
        if (sum > SAMPLE_MAX)
            sat = SAMPLE_MAX[SAMPLE_W-1:0];
        else if (sum < SAMPLE_MIN)
            sat = SAMPLE_MIN[SAMPLE_W-1:0];
        else
            sat = sum[SAMPLE_W-1:0];
    end

    assign load_ready = !valid_reg || m_tready;

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load && load_ready)
        begin
            data_reg <= sat;
            last_reg <= last_in;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load_ready)
            valid_reg <= load;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

/* rtl/linear_interp_resampler.sv */
// Top level of the streaming linear-interpolation sample rate converter.
//
// Input stream s_*: one signed 16-bit sample per request. Output stream m_*:
// interpolated samples, m_tlast set on the last output caused by an input.
// cfg_wr_en/cfg_wr_data load the 20-bit phase step (2^FRAC_BITS / ratio);
// write it only while the block is idle.
//
// The first sample after reset only primes the previous-sample store. An
// input arriving while the phase holds a whole period produces nothing.
// Otherwise each output needs an issue step, one pass of the bit-serial
// multiplier and a load into the result register, and s_tready stays low
// until the last output of the run is loaded: no new input is taken while
// a run is in progress. At most MAX_RUN outputs are made per input.
//
// The result register decouples the output: a stalled receiver only holds
// up the next output load; an input can be taken while the final output of
// the previous run still waits. Reset clears phase, previous sample, the
// primed flag and the output valid, and sets the step to 32768.
module linear_interp_resampler #(
    parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF,
    parameter int MAX_RUN   = lir_pkg::MAX_RUN_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample_in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lir_pkg::SAMPLE_W-1:0]      s_tdata,
    // sample_out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lir_pkg::SAMPLE_W-1:0]      m_tdata,
    // last_of_run
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [lir_pkg::STEP_W-1:0]        cfg_wr_data
);
    import lir_pkg::*;

    localparam int RUN_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam logic [PHASE_W:0] ONE = {{PHASE_W{1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [RUN_W-1:0] RUN_LAST = RUN_W'(MAX_RUN - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_EMIT
    } state_t;

    state_t                     state_reg, state_next;
    logic        [PHASE_W-1:0]  phase_reg, phase_next;
    logic signed [SAMPLE_W-1:0] prev_reg, prev_next;
    logic signed [SAMPLE_W-1:0] cur_reg, cur_next;
    logic                       primed_reg, primed_next;
    logic        [STEP_W-1:0]   step_reg, step_next;
    logic        [RUN_W-1:0]    run_reg, run_next;

    logic                       in_req;
    logic        [PHASE_W:0]    phase_wide;
    logic        [PHASE_W:0]    phase_sum;
    logic                       run_end;
    logic                       mul_start;
    logic signed [DIFF_W-1:0]   mul_diff;
    logic        [FRAC_BITS-1:0] mul_frac;
    logic                       mul_done;
    mul_res_t                   mul_res;
    logic                       out_load;
    logic                       out_ready;

    assign s_tready   = (state_reg == S_IDLE);
    assign in_req     = s_tvalid && s_tready;
    assign phase_wide = {1'b0, phase_reg};
    assign phase_sum  = phase_wide + {1'b0, step_reg};
    assign run_end    = (phase_sum >= ONE) || (run_reg == RUN_LAST);
    assign out_load   = (state_reg == S_EMIT);

    // Sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        prev_next   = prev_reg;
        cur_next    = cur_reg;
        primed_next = primed_reg;
        step_next   = cfg_wr_en ? cfg_wr_data : step_reg;
        run_next    = run_reg;
        mul_start   = 1'b0;
        mul_diff    = DIFF_W'(cur_reg) - DIFF_W'(prev_reg);
        mul_frac    = phase_sum[FRAC_BITS-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                mul_diff = DIFF_W'($signed(s_tdata)) - DIFF_W'(prev_reg);
                mul_frac = phase_reg[FRAC_BITS-1:0];
                if (in_req)
                begin
                    priority if (!primed_reg)
                    begin
                        prev_next   = $signed(s_tdata);
                        primed_next = 1'b1;
                    end
                    else if (phase_wide >= ONE)
                    begin
                        // whole period left over: input consumed without output
                        phase_next = PHASE_W'(phase_wide - ONE);
                        prev_next  = $signed(s_tdata);
                    end
                    else
                    begin
                        cur_next   = $signed(s_tdata);
                        run_next   = '0;
                        mul_start  = 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                if (mul_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    if (run_end)
                    begin
                        // close the interval, carry the excess phase or clear it on a capped run
                        phase_next = (phase_sum >= ONE) ? PHASE_W'(phase_sum - ONE) : '0;
                        prev_next  = cur_reg;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        phase_next = PHASE_W'(phase_sum);
                        run_next   = run_reg + RUN_W'(1);
                        mul_start  = 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= '0;
            prev_reg   <= '0;
            cur_reg    <= '0;
            primed_reg <= 1'b0;
            step_reg   <= STEP_RESET;
            run_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            prev_reg   <= prev_next;
            cur_reg    <= cur_next;
            primed_reg <= primed_next;
            step_reg   <= step_next;
            run_reg    <= run_next;
        end
    end

    // Interpolation weight times sample difference
    lir_serial_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .diff  (mul_diff),
        .frac  (mul_frac),
        .done  (mul_done),
        .res   (mul_res)
    );

    // Rounding, saturation and result register
    lir_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (out_load),
        .load_ready (out_ready),
        .base       (prev_reg),
        .res        (mul_res),
        .last_in    (run_end),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

/* rtl/lir_checker.sv */
// Port-level checks of the resampler, bound to the top level.
module lir_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [lir_pkg::SAMPLE_W-1:0] m_tdata,
    input logic                         m_tlast
);
    import lir_pkg::*;

    // A stalled output keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

    // An offered output carries defined data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !$isunknown({m_tdata, m_tlast}))
    else $error("output request with unknown payload");

    // Input stays blocked while a run still has outputs to make
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |-> !s_tready)
    else $error("input accepted in the middle of a run");

    // No output is pending when reset is released
    assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
    else $error("output valid out of reset");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* sim/tb_linear_interp_resampler.sv */
// Testbench for linear_interp_resampler: directed and random sample streams with a predictor.
module tb_linear_interp_resampler;
    import lir_pkg::*;

    localparam int     FRAC       = FRAC_BITS_DEF;
    localparam int     RUN_CAP    = MAX_RUN_DEF;
    localparam longint ONE_PERIOD = longint'(1) << FRAC;
    localparam longint HALF_LSB   = ONE_PERIOD >> 1;
    localparam longint FRAC_MASK  = ONE_PERIOD - 1;
    localparam longint PHASE_MASK = (longint'(1) << PHASE_W) - 1;
    localparam int     SETTLE     = 2 * (FRAC + 2) + 8;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smp;
        logic                       last;
    } out_sample_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata     = '0;   // [15:0] sample_in
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [SAMPLE_W-1:0] m_tdata;            // [15:0] sample_out
    logic                m_tlast;            // last_of_run
    logic                cfg_wr_en   = 1'b0;
    logic [STEP_W-1:0]   cfg_wr_data = '0;

    // Stimulus and expectation stores
    logic [SAMPLE_W-1:0] samples_to_send[$];
    out_sample_t         interp_queue[$];
    int                  err_cnt  = 0;
    logic                in_taken = 1'b0;

    // Idle controls, changed by the sequence at rising edges
    int   tx_idle     = 17;
    int   rx_idle     = 82;
    logic rx_hold     = 1'b0;
    logic rx_hold_req = 1'b0;

    // Model state
    logic signed [SAMPLE_W-1:0] prev_smp  = '0;
    longint                     phase_acc = 0;
    bit                         primed    = 1'b0;
    logic [STEP_W-1:0]          step_reg  = STEP_RESET;

    linear_interp_resampler DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // Interpolated outputs caused by one input sample
    function automatic void interp_run(input logic signed [SAMPLE_W-1:0] cur);
        int          n;
        longint      frac;
        longint      acc;
        out_sample_t r;
        if (!primed)
        begin
            // first sample only loads the history
            prev_smp = cur;
            primed   = 1'b1;
            return;
        end
        n = 0;
        while (phase_acc < ONE_PERIOD && n < RUN_CAP)
        begin
            frac = phase_acc & FRAC_MASK;
            acc  = longint'(prev_smp) * (ONE_PERIOD - frac) + longint'(cur) * frac + HALF_LSB;
            acc  = acc >>> FRAC;
            if (acc > 32767)
                acc = 32767;
            else if (acc < -32768)
                acc = -32768;
            n++;
            phase_acc += longint'(step_reg);
            r.smp  = acc[SAMPLE_W-1:0];
            r.last = !(phase_acc < ONE_PERIOD && n < RUN_CAP);
            interp_queue.push_back(r);
        end
        // skipped input or end of run; a capped run drops the rest
        phase_acc = (phase_acc >= ONE_PERIOD) ? phase_acc - ONE_PERIOD : 0;
        phase_acc &= PHASE_MASK;
        prev_smp = cur;
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        unique case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Step register write, only issued while idle
    task automatic write_step(input logic [STEP_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Wait until all requests are taken and all outputs have arrived
    task automatic drain();
        int guard;
        guard = 0;
        while ((samples_to_send.size() != 0 || s_tvalid || interp_queue.size() != 0)
               && guard < 400000)
        begin
            @(posedge clk);
            guard++;
        end
        if (interp_queue.size() != 0)
        begin
            $error("%0d expected output samples never arrived", interp_queue.size());
            err_cnt++;
            interp_queue.delete();
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // Input driver
    always @(negedge clk)
    begin
        if (!s_tvalid || in_taken)
        begin
            if (rst_n && samples_to_send.size() != 0 && $urandom_range(99) >= tx_idle)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= samples_to_send.pop_front();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output ready, with long hold-off on request
    always @(negedge clk)
    begin
        m_tready <= rst_n && !rx_hold && ($urandom_range(99) >= rx_idle);
    end

    // Long receiver hold-off, counted here once requested
    initial
    begin
        wait (rx_hold_req);
        rx_hold = 1'b1;
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
    end

    // Monitor: check outputs, predict on each accepted input request
    always @(posedge clk)
    begin : monitor
        out_sample_t want;
        if (rst_n)
        begin
            in_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                if (interp_queue.size() == 0)
                begin
                    $error("unexpected output: sample_out=%0d last_of_run=%0b",
                           $signed(m_tdata), m_tlast);
                    err_cnt++;
                end
                else
                begin
                    want = interp_queue.pop_front();
                    if (m_tdata !== want.smp)
                    begin
                        $error("sample_out: expected %0d, got %0d",
                               want.smp, $signed(m_tdata));
                        err_cnt++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_of_run: expected %0b, got %0b", want.last, m_tlast);
                        err_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                interp_run(s_tdata);
            if (cfg_wr_en)
                step_reg = cfg_wr_data;
        end
    end

    // Run limit
    initial
    begin
        #30000000;
        $display("tb_linear_interp_resampler failed");
        $finish;
    end

    // Sequence
    initial
    begin
        int                ph;
        int                k;
        int                n_items;
        logic [STEP_W-1:0] st;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset step: priming, then full-scale swings
        samples_to_send.push_back(16'h8000);
        samples_to_send.push_back(16'h7FFF);
        samples_to_send.push_back(16'h8000);
        samples_to_send.push_back(16'h0000);
        samples_to_send.push_back(16'hFFFF);
        samples_to_send.push_back(16'h0001);
        drain();

        // Step of 512: full 64-output runs across the whole fraction range
        write_step(20'd512);
        @(posedge clk);
        samples_to_send.push_back(16'h8000);
        samples_to_send.push_back(16'h7FFF);
        samples_to_send.push_back(16'h8000);
        drain();

        // Largest step: one output then skipped inputs
        write_step(20'd524288);
        @(posedge clk);
        samples_to_send.push_back(16'h7FFF);
        samples_to_send.push_back(16'h8000);
        samples_to_send.push_back(16'h0001);
        samples_to_send.push_back(16'hFFFF);
        drain();

        // Zero step: run cap with frozen phase
        write_step(20'd0);
        @(posedge clk);
        samples_to_send.push_back(16'h3039);
        samples_to_send.push_back(16'h8000);
        drain();

        // Step below the cap limit: run cut short, phase dropped to zero
        write_step(20'd300);
        @(posedge clk);
        samples_to_send.push_back(16'h7FFF);
        samples_to_send.push_back(16'h8000);
        drain();

        // Random phases over a spread of rate factors
        for (ph = 0; ph < 12; ph++)
        begin
            n_items = 30;
            unique case (ph % 6)
                0: st = STEP_W'($urandom_range(524288, 512));
                1: st = STEP_W'($urandom_range(65536, 16384));
                2:
                begin
                    st      = STEP_W'($urandom_range(4095, 512));
                    n_items = 8;
                end
                3: st = (ph < 6) ? 20'd524287 : STEP_W'($urandom_range(524288, 262144));
                4: st = STEP_W'($urandom_range(40000, 24000));
                default: st = STEP_W'($urandom_range(16383, 4096));
            endcase
            write_step(st);
            @(posedge clk);
            if (ph < 4)
            begin
                tx_idle = 17;
                rx_idle = 82;
            end
            else if (ph < 8)
            begin
                tx_idle = 82;
                rx_idle = 17;
            end
            else
            begin
                tx_idle = 0;
                rx_idle = 0;
            end

            if (ph == 7)
            begin
                // sender stops until every output is back
                for (k = 0; k < n_items / 2; k++)
                    samples_to_send.push_back(rand_sample());
                drain();
                for (k = n_items / 2; k < n_items; k++)
                    samples_to_send.push_back(rand_sample());
            end
            else
            begin
                for (k = 0; k < n_items; k++)
                    samples_to_send.push_back(rand_sample());
            end

            if (ph == 1)
            begin
                // long receiver stall so the block backs up onto its input
                rx_hold_req = 1'b1;
            end
            drain();
        end

        if (err_cnt == 0)
            $display("tb_linear_interp_resampler passed");
        else
            $display("tb_linear_interp_resampler failed");
        $finish;
    end

endmodule
